// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HSFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define HSFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/hsfc_pkg.sv
package hsfc_pkg;

   // crc-8 of each measurement word
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // conversion constants, numerators doubled for round to nearest
   localparam logic [16:0] FULL_SCALE  = 17'd65535;
   localparam logic [11:0] TEMP_SCALE2 = 12'd3500;
   localparam logic [11:0] HUMI_SCALE2 = 12'd2000;
   localparam logic [11:0] TEMP_OFFSET = 12'd450;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [11:0] temperature_deci;
      logic [9:0]         humidity_permille;
      logic               temp_crc_ok;
      logic               humi_crc_ok;
      logic               frame_valid;
   } rsp_type;

   // one complete frame, handed from front to back
   typedef struct packed {
      logic [15:0] temp_raw;
      logic [15:0] humi_raw;
      logic        temp_ok;
      logic        humi_ok;
   } frame_type;

   // one byte through the crc, msb first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/hsfc_front.sv
`include "assert_macros.svh"

module hsfc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsfc_pkg::req_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsfc_pkg::frame_type out_data
);
   import hsfc_pkg::*;

   // byte positions within a frame
   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUMI_MSB = 3'd3;
   localparam logic [2:0] POS_HUMI_LSB = 3'd4;
   localparam logic [2:0] POS_HUMI_CRC = 3'd5;

   logic [2:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_raw_ff, temp_raw_in;
   logic [15:0] humi_raw_ff, humi_raw_in;
   logic        temp_ok_ff, temp_ok_in;
   logic [2:0]  pos;
   logic        accept;
   logic        humi_ok;

   assign in_ready = out_ready;
   assign accept   = in_valid && in_ready;

   // position of this byte; frame start and unused counts restart the frame
   always_comb begin
      if (in_data.frame_start || count_ff > POS_HUMI_CRC) begin
         pos = POS_TEMP_MSB;
      end else begin
         pos = count_ff;
      end
   end

   assign humi_ok = (crc_ff == in_data.rx_byte);

   // byte assembly and running crc
   always_comb begin
      count_in    = count_ff;
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      humi_raw_in = humi_raw_ff;
      temp_ok_in  = temp_ok_ff;
      if (accept) begin
         case (pos)
            POS_TEMP_MSB: begin
               temp_raw_in[15:8] = in_data.rx_byte;
               crc_in = crc8_update(CRC_INIT, in_data.rx_byte);
            end
            POS_TEMP_LSB: begin
               temp_raw_in[7:0] = in_data.rx_byte;
               crc_in = crc8_update(crc_ff, in_data.rx_byte);
            end
            POS_TEMP_CRC: begin
               temp_ok_in = (crc_ff == in_data.rx_byte);
               crc_in     = CRC_INIT;
            end
            POS_HUMI_MSB: begin
               humi_raw_in[15:8] = in_data.rx_byte;
               crc_in = crc8_update(CRC_INIT, in_data.rx_byte);
            end
            POS_HUMI_LSB: begin
               humi_raw_in[7:0] = in_data.rx_byte;
               crc_in = crc8_update(crc_ff, in_data.rx_byte);
            end
            default: begin
               crc_in = CRC_INIT;
            end
         endcase
         if (pos == POS_HUMI_CRC) begin
            count_in = POS_TEMP_MSB;
         end else begin
            count_in = pos + 3'd1;
         end
      end
   end

   // push a finished frame on the last byte
   assign out_valid         = accept && (pos == POS_HUMI_CRC);
   assign out_data.temp_raw = temp_raw_ff;
   assign out_data.humi_raw = humi_raw_ff;
   assign out_data.temp_ok  = temp_ok_ff;
   assign out_data.humi_ok  = humi_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= POS_TEMP_MSB;
         crc_ff      <= CRC_INIT;
         temp_raw_ff <= '0;
         humi_raw_ff <= '0;
         temp_ok_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         temp_raw_ff <= temp_raw_in;
         humi_raw_ff <= humi_raw_in;
         temp_ok_ff  <= temp_ok_in;
      end
   end

   `HSFC_ASSERT_NOW(a_count_in_frame, clock, reset, 1'b1, count_ff <= POS_HUMI_CRC)
   `HSFC_ASSERT_NEXT(a_push_restarts, clock, reset, out_valid, count_ff == POS_TEMP_MSB && crc_ff == CRC_INIT)

endmodule

// File: rtl/hsfc_queue.sv
`include "assert_macros.svh"

module hsfc_queue #(
   parameter int DEPTH = hsfc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsfc_pkg::frame_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsfc_pkg::frame_type out_data
);
   import hsfc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // frame storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   `HSFC_ASSERT_NEXT(a_fill_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1)
   `HSFC_ASSERT_NEXT(a_fill_down, clock, reset, pop && !push, count_ff == $past(count_ff) - 1)
   `HSFC_ASSERT_NOW(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

// File: rtl/hsfc_back.sv
`include "assert_macros.svh"

module hsfc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsfc_pkg::frame_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsfc_pkg::rsp_type   out_data
);
   import hsfc_pkg::*;

   // floor(m / 65535) for m below 2^27: estimate, then one correction
   function automatic logic [11:0] div_full_scale(input logic [26:0] m);
      logic [27:0] est;
      logic [11:0] q0;
      logic [27:0] rem;
      est = {1'b0, m} + 28'(m[26:16]);
      q0  = est[27:16];
      rem = {1'b0, m} - {q0, 16'b0} + 28'(q0);
      if (rem >= 28'(FULL_SCALE)) begin
         return q0 + 12'd1;
      end
      return q0;
   endfunction

   logic        s1_valid_ff;
   logic [26:0] s1_temp_num_ff, s1_humi_num_ff;
   logic        s1_temp_ok_ff, s1_humi_ok_ff;
   logic        out_valid_ff;
   rsp_type     out_data_ff, out_data_in;
   logic [27:0] temp_prod, humi_prod;
   logic [11:0] temp_q, humi_q;
   logic        out_take, s1_move;

   // pipeline flow: output register frees, stage one moves up
   assign out_take = !out_valid_ff || out_ready;
   assign s1_move  = s1_valid_ff && out_take;
   assign in_ready = !s1_valid_ff || out_take;

   // stage one: scale and add half of the divisor
   assign temp_prod = 28'(in_data.temp_raw) * 28'(TEMP_SCALE2) + 28'(FULL_SCALE);
   assign humi_prod = 28'(in_data.humi_raw) * 28'(HUMI_SCALE2) + 28'(FULL_SCALE);

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_temp_num_ff <= temp_prod[27:1];
         s1_humi_num_ff <= humi_prod[27:1];
         s1_temp_ok_ff  <= in_data.temp_ok;
         s1_humi_ok_ff  <= in_data.humi_ok;
      end
   end

   // stage two: divide by full scale and offset
   assign temp_q = div_full_scale(s1_temp_num_ff);
   assign humi_q = div_full_scale(s1_humi_num_ff);

   always_comb begin
      out_data_in.temperature_deci  = signed'(temp_q - TEMP_OFFSET);
      out_data_in.humidity_permille = humi_q[9:0];
      out_data_in.temp_crc_ok       = s1_temp_ok_ff;
      out_data_in.humi_crc_ok       = s1_humi_ok_ff;
      out_data_in.frame_valid       = s1_temp_ok_ff && s1_humi_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (out_take) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   `HSFC_ASSERT_NOW(a_humi_range, clock, reset, out_valid_ff, out_data_ff.humidity_permille <= 10'd1000)
   `HSFC_ASSERT_NOW(a_temp_range, clock, reset, out_valid_ff, out_data_ff.temperature_deci >= -12'sd450 && out_data_ff.temperature_deci <= 12'sd1300)
   `HSFC_ASSERT_NOW(a_valid_and, clock, reset, out_valid_ff, out_data_ff.frame_valid == (out_data_ff.temp_crc_ok && out_data_ff.humi_crc_ok))

endmodule

// File: rtl/humidity_sensor_frame_check.sv
// a frame taken with its sixth byte passes the queue, stage one and output register
// one byte per cycle while rsp_ready is high; the queue and converter keep pace
// the two stage converter: one 16x12 multiply per channel, then a constant divide
// reset: synchronous, clears byte position, crc to ff, queue and pipeline valids
// no clearing pass; the block takes bytes as soon as reset is released
module humidity_sensor_frame_check #(
   parameter int QUEUE_DEPTH = hsfc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hsfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hsfc_pkg::rsp_type rsp_data
);
   import hsfc_pkg::*;

   logic      fr_valid, fr_ready;
   frame_type fr_data;
   logic      q_valid, q_ready;
   frame_type q_data;

   // byte assembly and crc check
   hsfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   // frame queue between front and converter
   hsfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // unit conversion and result word
   hsfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
